>>> rtl/aeci_pkg.sv
// ----------------------------------------------------------------------------
// aeci_pkg
// Shared types and constants of the ADC energy calibration block.
// ----------------------------------------------------------------------------
package aeci_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_BEAM_MODE     = 2'd0;
  localparam logic [1:0] REG_CHANNEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_BINS_IN_USE   = 2'd2;

  // request kinds
  localparam logic REQ_HIT  = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_BIN  = 2'd1;
  localparam logic [1:0] ST_BAD_CTR = 2'd2;

  // energy of a hit with no bin, Q.8 keV
  localparam logic signed [31:0] NO_BIN_ENERGY = -32'sd2560000;

  // widths of the interpolation datapath
  localparam int MAG_W = 48;
  localparam int DEN_W = 16;
  localparam int SUM_W = 51;
  localparam logic signed [SUM_W-1:0] E40_MAX = 51'sd549755813887;
  localparam logic signed [SUM_W-1:0] E40_MIN = -51'sd549755813888;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        cal_flag;
    logic [1:0]        module_req;
    logic [3:0]        asic;
    logic              side;
    logic [6:0]        strip;
    logic [31:0]       hit_time;
    logic [15:0]       adc;
    logic [8:0]        bin_index;
    logic [15:0]       bin_low;
    logic [15:0]       bin_high;
    logic signed [31:0] bin_energy;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        out_module;
    logic [3:0]        out_asic;
    logic              out_side;
    logic [6:0]        out_strip;
    logic signed [39:0] energy;
    logic [31:0]       out_time;
    logic [1:0]        status;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [12:0] wdata;
  } cfg_word_t;

  // command passed from front to back through the queue
  typedef struct packed {
    logic              is_load;
    logic [1:0]        module_req;
    logic [3:0]        asic;
    logic              side;
    logic [6:0]        strip;
    logic [31:0]       hit_time;
    logic [15:0]       adc;
    logic [8:0]        bin_index;
    logic [15:0]       bin_low;
    logic [15:0]       bin_high;
    logic signed [31:0] bin_energy;
  } cmd_t;

  // queue pop request driven by the back end, with the queue empty flag
  typedef struct packed {
    logic pop;
    logic empty;
  } q_ctl_t;

endpackage

>>> rtl/aeci_stream_if.sv
// ----------------------------------------------------------------------------
// aeci_stream_if
// Valid/ready channel carrying one word of any packed type.
// ----------------------------------------------------------------------------
interface aeci_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/aeci_fifo.sv
// ----------------------------------------------------------------------------
// aeci_fifo
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module aeci_fifo
  import aeci_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/aeci_front.sv
// ----------------------------------------------------------------------------
// aeci_front
// Accepts input words, drops rejected hits and out of range loads.
// ----------------------------------------------------------------------------
module aeci_front
  import aeci_pkg::*;
#(
  parameter int CHANNELS = 4096,
  parameter int BINS     = 512
) (
  aeci_stream_if.sink in,
  input  logic        beam_mode,
  input  logic [12:0] channel_limit,
  input  logic        clearing,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  logic [12:0] slot;
  logic        flag_ok;
  logic        keep;

  assign in.ready = !q_full && !clearing;

  // classify
  always_comb begin
    slot    = {1'b0, in.data.side, in.data.asic, in.data.strip};
    flag_ok = beam_mode ? (in.data.cal_flag == 2'd1)
                        : (in.data.cal_flag inside {2'd1, 2'd2});
    if (in.data.req_type == REQ_LOAD) begin
      keep = ({2'b0, in.data.bin_index} < 11'(BINS)) && (slot < 13'(CHANNELS));
    end else begin
      keep = flag_ok && ((slot + 13'd1) < channel_limit) && (slot < 13'(CHANNELS));
    end
  end

  assign push = in.valid && in.ready && keep;

  // command word
  always_comb begin
    cmd.is_load    = (in.data.req_type == REQ_LOAD);
    cmd.module_req = in.data.module_req;
    cmd.asic       = in.data.asic;
    cmd.side       = in.data.side;
    cmd.strip      = in.data.strip;
    cmd.hit_time   = in.data.hit_time;
    cmd.adc        = in.data.adc;
    cmd.bin_index  = in.data.bin_index;
    cmd.bin_low    = in.data.bin_low;
    cmd.bin_high   = in.data.bin_high;
    cmd.bin_energy = in.data.bin_energy;
  end

endmodule

>>> rtl/aeci_div.sv
// ----------------------------------------------------------------------------
// aeci_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aeci_div
  import aeci_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [MAG_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] acc;
  logic [DEN_W-1:0] r;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] steps;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {r, acc[MAG_W-1]};
  assign fits  = (trial >= {1'b0, d});
  assign quot  = acc;
  assign rem   = r;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(MAG_W);
      end else if (busy) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      r   <= '0;
      d   <= divisor;
    end else if (busy) begin
      acc <= {acc[MAG_W-2:0], fits};
      r   <= fits ? DEN_W'(trial - {1'b0, d}) : trial[DEN_W-1:0];
    end
  end

endmodule

>>> rtl/aeci_back.sv
// ----------------------------------------------------------------------------
// aeci_back
// Bin table, loaded flags, bin search and interpolation sequencer.
// ----------------------------------------------------------------------------
module aeci_back
  import aeci_pkg::*;
#(
  parameter int CHANNELS = 4096,
  parameter int BINS     = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  output q_ctl_t      q_ctl,
  input  logic        q_empty,
  input  logic [9:0]  bins_in_use,
  output logic        clearing,
  aeci_stream_if.source out
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BIN_W = $clog2(BINS);
  localparam int CNT_W = $clog2(BINS + 1);
  localparam int AW    = CH_W + BIN_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_SRCH  = 9'b000001000,
    S_NB    = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_START = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state;

  logic [63:0]       bin_mem [2**AW];
  logic              loaded_mem [CHANNELS];
  logic [63:0]       rd;
  logic              loaded_q;
  logic [AW-1:0]     rd_addr;
  logic [CH_W-1:0]   clr_idx;

  cmd_t              hit;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  n;
  logic [BIN_W-1:0]  p;
  logic [15:0]       p_low;
  logic [15:0]       p_c;
  logic signed [31:0] p_e;
  logic [15:0]       dx;
  logic [31:0]       de_mag;
  logic              neg;
  logic [DEN_W-1:0]  den;
  logic signed [31:0] e0;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W:0]    qr;
  logic [1:0]        status;

  logic              pop;
  logic              out_push;
  logic              out_free;
  logic [CH_W-1:0]   hit_slot;
  logic [CH_W-1:0]   head_slot;
  logic [15:0]       rd_low;
  logic [15:0]       rd_high;
  logic signed [31:0] rd_e;
  logic [15:0]       rd_c;
  logic              in_bin;
  logic [BIN_W-1:0]  nb_idx;
  logic [CNT_W-1:0]  n_sel;
  logic [15:0]       c1;
  logic [15:0]       c2;
  logic signed [31:0] e1;
  logic signed [31:0] e2;
  logic [32:0]       de;
  logic              div_done;
  logic [MAG_W-1:0]  div_q;
  logic [DEN_W-1:0]  div_r;
  logic signed [SUM_W-1:0] sum;
  logic signed [39:0] energy_sat;

  assign clearing   = (state == S_CLEAR);
  assign pop        = (state == S_IDLE) && !q_empty;
  assign q_ctl.pop   = pop;
  assign q_ctl.empty = q_empty;
  assign out_free   = !out.valid || out.ready;
  assign out_push   = (state == S_FIN) && out_free;

  assign hit_slot  = CH_W'({hit.side, hit.asic, hit.strip});
  assign head_slot = CH_W'({head.side, head.asic, head.strip});

  // fields of the bin just read
  always_comb begin
    rd_low  = rd[63:48];
    rd_high = rd[47:32];
    rd_e    = rd[31:0];
    rd_c    = 16'(({1'b0, rd_low} + {1'b0, rd_high}) >> 1);
    in_bin  = (hit.adc >= rd_low) && (hit.adc <= rd_high);
    nb_idx  = (i == '0) ? BIN_W'(1) : BIN_W'(i - CNT_W'(1));
    n_sel   = ({1'b0, bins_in_use} < 11'(BINS)) ? CNT_W'(bins_in_use) : CNT_W'(BINS);
  end

  // neighbour ordering and differences
  always_comb begin
    if (p == '0) begin
      c1 = p_c;  e1 = p_e;  c2 = rd_c; e2 = rd_e;
    end else begin
      c1 = rd_c; e1 = rd_e; c2 = p_c;  e2 = p_e;
    end
    de = {e2[31], e2} - {e1[31], e1};
  end

  // bin table read address
  always_comb begin
    case (state)
      S_CHK:   rd_addr = {hit_slot, BIN_W'(0)};
      S_SRCH:  rd_addr = in_bin ? {hit_slot, nb_idx} : {hit_slot, BIN_W'(i + CNT_W'(1))};
      default: rd_addr = '0;
    endcase
  end

  // bin table
  always_ff @(posedge clk) begin
    if (pop && head.is_load) begin
      bin_mem[{head_slot, BIN_W'(head.bin_index)}] <=
        {head.bin_low, head.bin_high, head.bin_energy};
    end
    rd <= bin_mem[rd_addr];
  end

  // loaded flags, cleared by a pass after reset
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      loaded_mem[clr_idx] <= 1'b0;
    end else if (pop && head.is_load) begin
      loaded_mem[head_slot] <= 1'b1;
    end
    loaded_q <= loaded_mem[head_slot];
  end

  aeci_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (mag),
    .divisor  (den),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CH_W'(1);
          if (clr_idx == CH_W'(CHANNELS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop && !head.is_load) state <= S_CHK;
        end
        S_CHK: begin
          if (!loaded_q) state <= S_IDLE;
          else if (n_sel == '0) state <= S_FIN;
          else state <= S_SRCH;
        end
        S_SRCH: begin
          if (in_bin) state <= S_NB;
          else if (CNT_W'(i + CNT_W'(1)) == n) state <= S_FIN;
        end
        S_NB: begin
          if (c2 <= c1) state <= S_FIN;
          else state <= S_MUL;
        end
        S_MUL:   state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (div_done) state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop) hit <= head;
      end
      S_CHK: begin
        n      <= n_sel;
        i      <= '0;
        qr     <= '0;
        neg    <= 1'b0;
        e0     <= NO_BIN_ENERGY;
        status <= ST_NO_BIN;
      end
      S_SRCH: begin
        if (in_bin) begin
          p     <= BIN_W'(i);
          p_low <= rd_low;
          p_c   <= rd_c;
          p_e   <= rd_e;
        end else begin
          i <= i + CNT_W'(1);
        end
      end
      S_NB: begin
        if (c2 <= c1) begin
          e0     <= '0;
          status <= ST_BAD_CTR;
        end else begin
          status <= ST_OK;
          e0     <= (p == '0) ? 32'sd0 : e1;
          dx     <= hit.adc - p_low;
          neg    <= de[32];
          de_mag <= de[32] ? 32'(-de) : de[31:0];
          den    <= c2 - c1;
        end
      end
      S_MUL: begin
        mag <= MAG_W'(dx) * MAG_W'(de_mag);
      end
      S_DIV: begin
        if (div_done) begin
          qr <= {1'b0, div_q} +
                (MAG_W+1)'(({div_r, 1'b0} >= {1'b0, den}) ? 1 : 0);
        end
      end
      default: begin
      end
    endcase
  end

  // final sum and saturation
  always_comb begin
    sum = (neg ? -$signed({2'b0, qr}) : $signed({2'b0, qr})) + SUM_W'(e0);
    if (sum > E40_MAX)      energy_sat = 40'(E40_MAX);
    else if (sum < E40_MIN) energy_sat = 40'(E40_MIN);
    else                    energy_sat = sum[39:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (out_push) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out.data.out_module <= hit.module_req;
      out.data.out_asic   <= hit.asic;
      out.data.out_side   <= hit.side;
      out.data.out_strip  <= hit.strip;
      out.data.energy     <= energy_sat;
      out.data.out_time   <= hit.hit_time;
      out.data.status     <= status;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !q_ctl.pop) else $error("queue popped during clear");
  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV)) else $error("divider finished outside wait");
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (i < n)) else $error("search past bins in use");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (!$past(out_push) || $past(state) != S_FIN || out.ready || !out.valid))
    else $error("output overwritten");
`endif

endmodule

>>> rtl/adc_energy_calibration_interp.sv
// After reset the block clears the loaded flags of all CHANNELS channels
// and takes no word in that time. A load word is written to the bin table
// as the back end pops it. A hit goes from acceptance through the queue
// pop, the first read, a linear search of at most bins_in_use bins, one bin
// per cycle from the single read port of the bin table, the neighbour bin
// read, the multiply and the 48-step serial divider to its output word.
// A two-word queue lets the front accept words while the back end works.
// ----------------------------------------------------------------------------
// adc_energy_calibration_interp
// Piecewise-linear ADC to energy calibration for strip channels.
// ----------------------------------------------------------------------------
module adc_energy_calibration_interp
  import aeci_pkg::*;
#(
  parameter int CHANNELS = 4096,
  parameter int BINS     = 512
) (
  input  logic clk,
  input  logic rst,
  aeci_stream_if.sink   in,
  aeci_stream_if.sink   cfg,
  aeci_stream_if.source out
);

  logic        beam_mode;
  logic [12:0] channel_limit;
  logic [9:0]  bins_in_use;
  logic        clearing;
  logic        q_full;
  logic        q_empty;
  logic        push;
  cmd_t        cmd;
  cmd_t        head;
  q_ctl_t      q_ctl;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_mode     <= 1'b0;
      channel_limit <= 13'd4097;
      bins_in_use   <= 10'd500;
    end else if (cfg.valid) begin
      case (cfg.data.reg_index)
        REG_BEAM_MODE:     beam_mode     <= cfg.data.wdata[0];
        REG_CHANNEL_LIMIT: channel_limit <= cfg.data.wdata;
        REG_BINS_IN_USE:   bins_in_use   <= cfg.data.wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  aeci_front #(.CHANNELS(CHANNELS), .BINS(BINS)) u_front (
    .in            (in),
    .beam_mode     (beam_mode),
    .channel_limit (channel_limit),
    .clearing      (clearing),
    .q_full        (q_full),
    .push          (push),
    .cmd           (cmd)
  );

  aeci_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .full      (q_full),
    .pop       (q_ctl.pop),
    .empty     (q_empty),
    .head      (head)
  );

  aeci_back #(.CHANNELS(CHANNELS), .BINS(BINS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_ctl       (q_ctl),
    .q_empty     (q_empty),
    .bins_in_use (bins_in_use),
    .clearing    (clearing),
    .out         (out)
  );

endmodule

>>> sim/aeci_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeci_scoreboard
// Watches the hit, configuration and energy channels of the calibration
// block, keeps its own copy of the bin tables and registers, works out the
// energy word each accepted hit should give and checks every output word
// against the oldest one still due.
// ----------------------------------------------------------------------------
module aeci_scoreboard
  import aeci_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_word_t cfg_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fails,
  output int        pending,
  output int        results
);

  // own copy of the bin tables, keyed by slot*512 + bin
  logic [15:0] lo_mem[int];
  logic [15:0] hi_mem[int];
  logic [31:0] e_mem[int];
  bit          live[int];

  logic        beam_mode;
  logic [12:0] chan_limit;
  logic [9:0]  bins_used;

  out_word_t energy_due[$];

  initial begin
    fails      = 0;
    pending    = 0;
    results    = 0;
    beam_mode  = 1'b0;
    chan_limit = 13'd4097;
    bins_used  = 10'd500;
  end

  task automatic report(string what, longint got, longint want);
    fails++;
    $display("%0t: energy word %0d: %s got %0d want %0d", $realtime, results, what, got, want);
  endtask

  // quotient rounded to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag, q, r;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    r = mag % den;
    if (2 * r >= den) q++;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint centre(int key);
    return (longint'(lo_mem[key]) + longint'(hi_mem[key])) >>> 1;
  endfunction

  // apply one input word: load a bin or calibrate a hit
  function automatic void calibrate(in_word_t w);
    int        slot, base, n, p, a, b;
    bit        found;
    longint    c1, c2, e1, e2, e0, en;
    out_word_t r;
    slot = {w.side, w.asic, w.strip};
    base = slot * 512;
    if (w.req_type == REQ_LOAD) begin
      lo_mem[base + w.bin_index] = w.bin_low;
      hi_mem[base + w.bin_index] = w.bin_high;
      e_mem[base + w.bin_index]  = w.bin_energy;
      live[slot] = 1'b1;
      return;
    end
    if (beam_mode ? (w.cal_flag != 2'd1) : (w.cal_flag != 2'd1 && w.cal_flag != 2'd2))
      return;
    if (slot + 1 >= chan_limit || !live.exists(slot))
      return;
    n = (bins_used < 512) ? bins_used : 512;
    found = 1'b0;
    p = 0;
    for (int i = 0; i < n && !found; i++) begin
      if (w.adc >= lo_mem[base + i] && w.adc <= hi_mem[base + i]) begin
        p = i;
        found = 1'b1;
      end
    end
    r.out_module = w.module_req;
    r.out_asic   = w.asic;
    r.out_side   = w.side;
    r.out_strip  = w.strip;
    r.out_time   = w.hit_time;
    if (!found) begin
      r.energy = 40'(longint'(NO_BIN_ENERGY));
      r.status = ST_NO_BIN;
    end else begin
      a = (p == 0) ? 0 : p - 1;
      b = a + 1;
      c1 = centre(base + a);
      c2 = centre(base + b);
      if (c2 <= c1) begin
        r.energy = '0;
        r.status = ST_BAD_CTR;
      end else begin
        e1 = longint'($signed(e_mem[base + a]));
        e2 = longint'($signed(e_mem[base + b]));
        e0 = (p == 0) ? 0 : e1;
        en = round_div((longint'(w.adc) - longint'(lo_mem[base + p])) * (e2 - e1), c2 - c1) + e0;
        if (en > 64'sd549755813887) en = 64'sd549755813887;
        if (en < -64'sd549755813888) en = -64'sd549755813888;
        r.energy = en[39:0];
        r.status = ST_OK;
      end
    end
    energy_due.push_back(r);
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      // compare an energy word with the oldest one due
      if (out_valid && out_ready) begin
        if (energy_due.size() == 0) begin
          report("unexpected word, status", out_data.status, -1);
        end else begin
          want = energy_due.pop_front();
          if (out_data.out_module != want.out_module)
            report("module", out_data.out_module, want.out_module);
          if (out_data.out_asic != want.out_asic)
            report("asic", out_data.out_asic, want.out_asic);
          if (out_data.out_side != want.out_side)
            report("side", out_data.out_side, want.out_side);
          if (out_data.out_strip != want.out_strip)
            report("strip", out_data.out_strip, want.out_strip);
          if (out_data.energy !== want.energy)
            report("energy", longint'(out_data.energy), longint'(want.energy));
          if (out_data.out_time !== want.out_time)
            report("time", out_data.out_time, want.out_time);
          if (out_data.status !== want.status)
            report("status", out_data.status, want.status);
        end
        results++;
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.reg_index)
          REG_BEAM_MODE:     beam_mode = cfg_data.wdata[0];
          REG_CHANNEL_LIMIT: chan_limit = cfg_data.wdata;
          REG_BINS_IN_USE:   bins_used = cfg_data.wdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) calibrate(in_data);
      pending = energy_due.size();
    end
  end

endmodule

>>> sim/tb_adc_energy_calibration_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_energy_calibration_interp
// Drives bin loads, hits and register writes into the calibration block
// under random stalls on both sides; the scoreboard beside the block does
// the checking and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_adc_energy_calibration_interp;
  import aeci_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int         PHASES    = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aeci_stream_if #(.T(in_word_t))  hit_if ();
  aeci_stream_if #(.T(cfg_word_t)) cfg_if ();
  aeci_stream_if #(.T(out_word_t)) res_if ();

  int fails, pending, results;

  adc_energy_calibration_interp dut (
    .clk (clk),
    .rst (rst),
    .in  (hit_if),
    .cfg (cfg_if),
    .out (res_if)
  );

  aeci_scoreboard sb (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hit_if.valid),
    .in_ready  (hit_if.ready),
    .in_data   (hit_if.data),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_data  (cfg_if.data),
    .out_valid (res_if.valid),
    .out_ready (res_if.ready),
    .out_data  (res_if.data),
    .fails     (fails),
    .pending   (pending),
    .results   (results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the registers and of which bins hold data
  logic        cur_beam;
  int          cur_limit;
  int          cur_bins;
  bit          loaded[int];
  bit          written[int];
  int          span[int];
  int          good[$];
  bit          calm = 1'b0;
  int          n_hits = 0;
  int          n_loads = 0;
  int          stall_left = 0;

  // energy side stalls in bursts
  initial res_if.ready = 1'b0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send(in_word_t w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      hit_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    hit_if.data  <= w;
    hit_if.valid <= 1'b1;
    @(negedge clk);
    while (!hit_if.ready) @(negedge clk);
    @(posedge clk);
    if (w.req_type == REQ_LOAD) n_loads++;
    else n_hits++;
  endtask

  task automatic cfg_write(logic [1:0] idx, int val);
    cfg_if.data  <= '{reg_index: idx, wdata: 13'(val)};
    cfg_if.valid <= 1'b1;
    @(negedge clk);
    while (!cfg_if.ready) @(negedge clk);
    @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_BEAM_MODE:     cur_beam = val[0];
      REG_CHANNEL_LIMIT: cur_limit = val;
      REG_BINS_IN_USE:   cur_bins = val & 10'h3ff;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait until the block has drained
  task automatic settle();
    hit_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (1500) @(posedge clk);
  endtask

  function automatic bit usable(int slot);
    for (int i = 0; i < cur_bins && i < 512; i++)
      if (!written.exists(slot * 512 + i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit flag_ok(logic [1:0] f);
    return cur_beam ? (f == 2'd1) : (f == 2'd1 || f == 2'd2);
  endfunction

  task automatic load(int slot, int bin, int lo, int hi, logic [31:0] e);
    in_word_t w;
    w = in_word_t'({10'($urandom), $urandom, $urandom, $urandom, $urandom});
    w.req_type   = REQ_LOAD;
    {w.side, w.asic, w.strip} = 12'(slot);
    w.bin_index  = 9'(bin);
    w.bin_low    = 16'(lo);
    w.bin_high   = 16'(hi);
    w.bin_energy = e;
    send(w);
    written[slot * 512 + bin] = 1'b1;
    loaded[slot] = 1'b1;
    if (!span.exists(slot) || hi > span[slot]) span[slot] = hi;
  endtask

  task automatic hit(int slot, logic [1:0] flag, int adc);
    in_word_t w;
    w = in_word_t'({10'($urandom), $urandom, $urandom, $urandom, $urandom});
    // a hit that would reach unwritten bins is turned into a dropped one
    if (flag_ok(flag) && slot + 1 < cur_limit && loaded.exists(slot) && !usable(slot))
      flag = 2'd0;
    w.req_type = REQ_HIT;
    w.cal_flag = flag;
    {w.side, w.asic, w.strip} = 12'(slot);
    w.adc = 16'(adc);
    send(w);
  endtask

  // load bins 0..n-1 of a channel, ordered edges or loose ones
  task automatic fill(int slot, int n, bit tidy);
    int width, lo, hi, e;
    width = $urandom_range(1, 65535 / n);
    e = $urandom_range(0, 200000) - 100000;
    for (int i = 0; i < n; i++) begin
      lo = i * width + (tidy ? 0 : $urandom_range(0, width - 1));
      hi = tidy ? lo + width - 1 : lo + $urandom_range(0, width);
      if (hi > 65535) hi = 65535;
      if ($urandom_range(0, 9) == 0) e = $urandom;
      else e = e + $urandom_range(0, 80000) - 30000;
      load(slot, i, lo, hi, e);
    end
  endtask

  int ph_beam[PHASES]  = '{1, 0, 0, 1, 0, 1, 0};
  int ph_limit[PHASES] = '{4097, 2000, 0, 1, 4097, 3000, 4097};
  int ph_bins[PHASES]  = '{2, 3, 5, 8, 512, 16, 7};
  int ph_items[PHASES] = '{70, 70, 40, 40, 50, 70, 70};

  initial begin
    int s1, s2, s3, slot, r, top;
    hit_if.valid = 1'b0;
    hit_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    cur_beam  = 1'b0;
    cur_limit = 4097;
    cur_bins  = 500;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part: saturation both ways, bad centres, missing bin
    cfg_write(REG_BEAM_MODE, 0);
    cfg_write(REG_CHANNEL_LIMIT, 4097);
    cfg_write(REG_BINS_IN_USE, 4);
    cfg_write(REG_SPARE, $urandom_range(0, 8191));
    s1 = 4095;
    s2 = 0;
    s3 = 1234;
    load(s1, 0, 1, 1, 0);
    load(s1, 1, 32766, 32766, 32'h8000_0000);
    load(s1, 2, 0, 65535, 32'h7fff_ffff);
    load(s1, 3, 5, 5, 0);
    load(s2, 0, 1, 1, 0);
    load(s2, 1, 32766, 32766, 32'h7fff_ffff);
    load(s2, 2, 0, 65535, 32'h8000_0000);
    load(s2, 3, 5, 5, 0);
    load(s3, 0, 100, 200, 1000);
    load(s3, 1, 0, 50, 2000);
    load(s3, 2, 300, 400, -3000);
    load(s3, 3, 500, 600, 4000);
    for (int f = 0; f < 4; f++) hit(s1, 2'(f), 65535);
    hit(s1, 2'd1, 1);
    hit(s1, 2'd2, 32766);
    hit(s1, 2'd1, 5);
    hit(s2, 2'd1, 65535);
    hit(s3, 2'd1, 150);
    hit(s3, 2'd2, 350);
    hit(s3, 2'd1, 0);
    hit(s3, 2'd1, 65535);
    hit(77, 2'd1, 300);

    // random phases over several register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == PHASES - 1) calm = 1'b1;
      cfg_write(REG_BEAM_MODE, ph_beam[ph]);
      cfg_write(REG_CHANNEL_LIMIT, ph_limit[ph]);
      cfg_write(REG_BINS_IN_USE, ph_bins[ph]);
      good.delete();
      foreach (loaded[s]) if (usable(s)) good.push_back(s);
      for (int k = 0; k < ((ph_bins[ph] >= 512) ? 1 : 3); k++) begin
        slot = $urandom_range(0, 4095);
        fill(slot, ph_bins[ph], $urandom_range(0, 3) != 0);
        good.push_back(slot);
      end
      for (int m = 0; m < ph_items[ph]; m++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          if ($urandom_range(0, 1) == 1)
            load(good[$urandom_range(0, good.size() - 1)],
                 $urandom_range(0, cur_bins - 1), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom);
          else
            load($urandom_range(0, 4095), $urandom_range(0, 511), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom);
        end else if (r < 30) begin
          hit($urandom_range(0, 4095), 2'($urandom_range(0, 3)), $urandom_range(0, 65535));
        end else begin
          slot = good[$urandom_range(0, good.size() - 1)];
          top = span[slot] + 64;
          if (top > 65535) top = 65535;
          hit(slot, (cur_beam || $urandom_range(0, 1) == 0) ? 2'd1 : 2'd2,
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, top));
        end
      end
    end

    settle();
    $display("run covered %0d hits and %0d bin loads over %0d register settings",
             n_hits, n_loads, PHASES + 1);
    $display("%0d energy words compared, %0d mismatches", results, fails);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
